[rtl/aes128_pkg.sv]
// ----------------------------------------------------------------------------
// aes128_pkg
// shared types, constants and byte-level functions for the aes-128 core
// ----------------------------------------------------------------------------
package aes128_pkg;

  localparam int BlockW = 128;
  localparam int HalfW  = 64;

  localparam logic OP_ENCRYPT = 1'b0;
  localparam logic OP_DECRYPT = 1'b1;

  localparam logic [0:0] REG_KEY_HIGH = 1'b0;
  localparam logic [0:0] REG_KEY_LOW  = 1'b1;

  typedef logic [BlockW-1:0] block_t;

  // sideband that travels with each word down the pipe
  typedef struct packed {
    logic   valid;
    logic   opcode;
  } ctl_t;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] r;
    case (a)
      8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
      8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
      8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
      8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
      8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
      8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
      8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
      8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
      8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
      8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
      8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
      8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
      8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
      8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
      8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
      8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
      8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
      8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
      8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
      8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
      8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
      8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
      8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
      8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
      8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
      8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
      8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
      8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
      8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
      8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
      8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
      8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
      8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
      8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
      8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
      8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
      8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
      8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
      8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
      8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
      8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
      8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
      8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
      8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
      8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
      8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
      8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
      8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
      8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
      8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
      8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
      8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
      8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
      8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
      8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
      8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
      8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
      8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
      8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
      8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
      8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
      8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
      8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
      8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; default: r=8'h16;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] inv_sbox(input logic [7:0] a);
    logic [7:0] r;
    case (a)
      8'h00: r=8'h52; 8'h01: r=8'h09; 8'h02: r=8'h6a; 8'h03: r=8'hd5;
      8'h04: r=8'h30; 8'h05: r=8'h36; 8'h06: r=8'ha5; 8'h07: r=8'h38;
      8'h08: r=8'hbf; 8'h09: r=8'h40; 8'h0a: r=8'ha3; 8'h0b: r=8'h9e;
      8'h0c: r=8'h81; 8'h0d: r=8'hf3; 8'h0e: r=8'hd7; 8'h0f: r=8'hfb;
      8'h10: r=8'h7c; 8'h11: r=8'he3; 8'h12: r=8'h39; 8'h13: r=8'h82;
      8'h14: r=8'h9b; 8'h15: r=8'h2f; 8'h16: r=8'hff; 8'h17: r=8'h87;
      8'h18: r=8'h34; 8'h19: r=8'h8e; 8'h1a: r=8'h43; 8'h1b: r=8'h44;
      8'h1c: r=8'hc4; 8'h1d: r=8'hde; 8'h1e: r=8'he9; 8'h1f: r=8'hcb;
      8'h20: r=8'h54; 8'h21: r=8'h7b; 8'h22: r=8'h94; 8'h23: r=8'h32;
      8'h24: r=8'ha6; 8'h25: r=8'hc2; 8'h26: r=8'h23; 8'h27: r=8'h3d;
      8'h28: r=8'hee; 8'h29: r=8'h4c; 8'h2a: r=8'h95; 8'h2b: r=8'h0b;
      8'h2c: r=8'h42; 8'h2d: r=8'hfa; 8'h2e: r=8'hc3; 8'h2f: r=8'h4e;
      8'h30: r=8'h08; 8'h31: r=8'h2e; 8'h32: r=8'ha1; 8'h33: r=8'h66;
      8'h34: r=8'h28; 8'h35: r=8'hd9; 8'h36: r=8'h24; 8'h37: r=8'hb2;
      8'h38: r=8'h76; 8'h39: r=8'h5b; 8'h3a: r=8'ha2; 8'h3b: r=8'h49;
      8'h3c: r=8'h6d; 8'h3d: r=8'h8b; 8'h3e: r=8'hd1; 8'h3f: r=8'h25;
      8'h40: r=8'h72; 8'h41: r=8'hf8; 8'h42: r=8'hf6; 8'h43: r=8'h64;
      8'h44: r=8'h86; 8'h45: r=8'h68; 8'h46: r=8'h98; 8'h47: r=8'h16;
      8'h48: r=8'hd4; 8'h49: r=8'ha4; 8'h4a: r=8'h5c; 8'h4b: r=8'hcc;
      8'h4c: r=8'h5d; 8'h4d: r=8'h65; 8'h4e: r=8'hb6; 8'h4f: r=8'h92;
      8'h50: r=8'h6c; 8'h51: r=8'h70; 8'h52: r=8'h48; 8'h53: r=8'h50;
      8'h54: r=8'hfd; 8'h55: r=8'hed; 8'h56: r=8'hb9; 8'h57: r=8'hda;
      8'h58: r=8'h5e; 8'h59: r=8'h15; 8'h5a: r=8'h46; 8'h5b: r=8'h57;
      8'h5c: r=8'ha7; 8'h5d: r=8'h8d; 8'h5e: r=8'h9d; 8'h5f: r=8'h84;
      8'h60: r=8'h90; 8'h61: r=8'hd8; 8'h62: r=8'hab; 8'h63: r=8'h00;
      8'h64: r=8'h8c; 8'h65: r=8'hbc; 8'h66: r=8'hd3; 8'h67: r=8'h0a;
      8'h68: r=8'hf7; 8'h69: r=8'he4; 8'h6a: r=8'h58; 8'h6b: r=8'h05;
      8'h6c: r=8'hb8; 8'h6d: r=8'hb3; 8'h6e: r=8'h45; 8'h6f: r=8'h06;
      8'h70: r=8'hd0; 8'h71: r=8'h2c; 8'h72: r=8'h1e; 8'h73: r=8'h8f;
      8'h74: r=8'hca; 8'h75: r=8'h3f; 8'h76: r=8'h0f; 8'h77: r=8'h02;
      8'h78: r=8'hc1; 8'h79: r=8'haf; 8'h7a: r=8'hbd; 8'h7b: r=8'h03;
      8'h7c: r=8'h01; 8'h7d: r=8'h13; 8'h7e: r=8'h8a; 8'h7f: r=8'h6b;
      8'h80: r=8'h3a; 8'h81: r=8'h91; 8'h82: r=8'h11; 8'h83: r=8'h41;
      8'h84: r=8'h4f; 8'h85: r=8'h67; 8'h86: r=8'hdc; 8'h87: r=8'hea;
      8'h88: r=8'h97; 8'h89: r=8'hf2; 8'h8a: r=8'hcf; 8'h8b: r=8'hce;
      8'h8c: r=8'hf0; 8'h8d: r=8'hb4; 8'h8e: r=8'he6; 8'h8f: r=8'h73;
      8'h90: r=8'h96; 8'h91: r=8'hac; 8'h92: r=8'h74; 8'h93: r=8'h22;
      8'h94: r=8'he7; 8'h95: r=8'had; 8'h96: r=8'h35; 8'h97: r=8'h85;
      8'h98: r=8'he2; 8'h99: r=8'hf9; 8'h9a: r=8'h37; 8'h9b: r=8'he8;
      8'h9c: r=8'h1c; 8'h9d: r=8'h75; 8'h9e: r=8'hdf; 8'h9f: r=8'h6e;
      8'ha0: r=8'h47; 8'ha1: r=8'hf1; 8'ha2: r=8'h1a; 8'ha3: r=8'h71;
      8'ha4: r=8'h1d; 8'ha5: r=8'h29; 8'ha6: r=8'hc5; 8'ha7: r=8'h89;
      8'ha8: r=8'h6f; 8'ha9: r=8'hb7; 8'haa: r=8'h62; 8'hab: r=8'h0e;
      8'hac: r=8'haa; 8'had: r=8'h18; 8'hae: r=8'hbe; 8'haf: r=8'h1b;
      8'hb0: r=8'hfc; 8'hb1: r=8'h56; 8'hb2: r=8'h3e; 8'hb3: r=8'h4b;
      8'hb4: r=8'hc6; 8'hb5: r=8'hd2; 8'hb6: r=8'h79; 8'hb7: r=8'h20;
      8'hb8: r=8'h9a; 8'hb9: r=8'hdb; 8'hba: r=8'hc0; 8'hbb: r=8'hfe;
      8'hbc: r=8'h78; 8'hbd: r=8'hcd; 8'hbe: r=8'h5a; 8'hbf: r=8'hf4;
      8'hc0: r=8'h1f; 8'hc1: r=8'hdd; 8'hc2: r=8'ha8; 8'hc3: r=8'h33;
      8'hc4: r=8'h88; 8'hc5: r=8'h07; 8'hc6: r=8'hc7; 8'hc7: r=8'h31;
      8'hc8: r=8'hb1; 8'hc9: r=8'h12; 8'hca: r=8'h10; 8'hcb: r=8'h59;
      8'hcc: r=8'h27; 8'hcd: r=8'h80; 8'hce: r=8'hec; 8'hcf: r=8'h5f;
      8'hd0: r=8'h60; 8'hd1: r=8'h51; 8'hd2: r=8'h7f; 8'hd3: r=8'ha9;
      8'hd4: r=8'h19; 8'hd5: r=8'hb5; 8'hd6: r=8'h4a; 8'hd7: r=8'h0d;
      8'hd8: r=8'h2d; 8'hd9: r=8'he5; 8'hda: r=8'h7a; 8'hdb: r=8'h9f;
      8'hdc: r=8'h93; 8'hdd: r=8'hc9; 8'hde: r=8'h9c; 8'hdf: r=8'hef;
      8'he0: r=8'ha0; 8'he1: r=8'he0; 8'he2: r=8'h3b; 8'he3: r=8'h4d;
      8'he4: r=8'hae; 8'he5: r=8'h2a; 8'he6: r=8'hf5; 8'he7: r=8'hb0;
      8'he8: r=8'hc8; 8'he9: r=8'heb; 8'hea: r=8'hbb; 8'heb: r=8'h3c;
      8'hec: r=8'h83; 8'hed: r=8'h53; 8'hee: r=8'h99; 8'hef: r=8'h61;
      8'hf0: r=8'h17; 8'hf1: r=8'h2b; 8'hf2: r=8'h04; 8'hf3: r=8'h7e;
      8'hf4: r=8'hba; 8'hf5: r=8'h77; 8'hf6: r=8'hd6; 8'hf7: r=8'h26;
      8'hf8: r=8'he1; 8'hf9: r=8'h69; 8'hfa: r=8'h14; 8'hfb: r=8'h63;
      8'hfc: r=8'h55; 8'hfd: r=8'h21; 8'hfe: r=8'h0c; default: r=8'h7d;
    endcase
    return r;
  endfunction

  // multiply by x in gf(2^8), reduction 0x1b
  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // byte n of a block sits at bits 127-8n
  function automatic logic [7:0] get_byte(input block_t s, input int n);
    return s[BlockW-1-8*n -: 8];
  endfunction

  function automatic block_t sub_bytes(input block_t s, input logic inv);
    block_t o;
    for (int n = 0; n < 16; n++) begin
      o[BlockW-1-8*n -: 8] = inv ? inv_sbox(get_byte(s, n)) : sbox(get_byte(s, n));
    end
    return o;
  endfunction

  function automatic block_t shift_rows(input block_t s, input logic inv);
    block_t o;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        if (inv) begin
          o[BlockW-1-8*(r+4*((c+r)%4)) -: 8] = get_byte(s, r + 4*c);
        end else begin
          o[BlockW-1-8*(r+4*c) -: 8] = get_byte(s, r + 4*((c+r)%4));
        end
      end
    end
    return o;
  endfunction

  function automatic block_t mix_columns(input block_t s);
    block_t o;
    logic [7:0] a0, a1, a2, a3;
    for (int c = 0; c < 4; c++) begin
      a0 = get_byte(s, 4*c);
      a1 = get_byte(s, 4*c+1);
      a2 = get_byte(s, 4*c+2);
      a3 = get_byte(s, 4*c+3);
      o[BlockW-1-8*(4*c)   -: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
      o[BlockW-1-8*(4*c+1) -: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
      o[BlockW-1-8*(4*c+2) -: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
      o[BlockW-1-8*(4*c+3) -: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
    end
    return o;
  endfunction

  // inverse mix: premultiply by {05,00,04,00} then forward mix
  function automatic block_t inv_mix_columns(input block_t s);
    block_t p;
    logic [7:0] u, v;
    for (int c = 0; c < 4; c++) begin
      u = xtime(xtime(get_byte(s, 4*c) ^ get_byte(s, 4*c+2)));
      v = xtime(xtime(get_byte(s, 4*c+1) ^ get_byte(s, 4*c+3)));
      p[BlockW-1-8*(4*c)   -: 8] = get_byte(s, 4*c)   ^ u;
      p[BlockW-1-8*(4*c+1) -: 8] = get_byte(s, 4*c+1) ^ v;
      p[BlockW-1-8*(4*c+2) -: 8] = get_byte(s, 4*c+2) ^ u;
      p[BlockW-1-8*(4*c+3) -: 8] = get_byte(s, 4*c+3) ^ v;
    end
    return mix_columns(p);
  endfunction

  // next round key, rcon supplied by caller
  function automatic block_t next_key(input block_t k, input logic [7:0] rc);
    logic [31:0] t;
    block_t o;
    t = {sbox(k[23:16]) ^ rc, sbox(k[15:8]), sbox(k[7:0]), sbox(k[31:24])};
    o[127:96] = k[127:96] ^ t;
    o[95:64]  = k[95:64]  ^ o[127:96];
    o[63:32]  = k[63:32]  ^ o[95:64];
    o[31:0]   = k[31:0]   ^ o[63:32];
    return o;
  endfunction

  function automatic logic [7:0] rcon(input int i);
    logic [7:0] r;
    r = 8'h01;
    for (int j = 0; j < 10; j++) begin
      if (j < i) r = xtime(r);
    end
    return r;
  endfunction

endpackage

[rtl/aes128_if.sv]
// ----------------------------------------------------------------------------
// aes128_if
// valid/ready channels for input and result words
// ----------------------------------------------------------------------------
interface aes128_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [63:0] block_high;
  logic [63:0] block_low;
  modport source (output valid, opcode, block_high, block_low, input ready);
  modport sink   (input valid, opcode, block_high, block_low, output ready);
endinterface

interface aes128_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] result_high;
  logic [63:0] result_low;
  modport source (output valid, result_high, result_low, input ready);
  modport sink   (input valid, result_high, result_low, output ready);
endinterface

[rtl/aes128_keysched.sv]
// ----------------------------------------------------------------------------
// aes128_keysched
// builds all eleven round keys from the key registers in a register chain
// ----------------------------------------------------------------------------
module aes128_keysched (
  input  logic                    clk,
  input  aes128_pkg::block_t      key,
  output aes128_pkg::block_t      round_key [11]
);

  // keys rebuilt continuously; user changes key only while idle, unenforced
  always_ff @(posedge clk) begin
    round_key[0] <= key;
    for (int i = 1; i < 11; i++) begin
      round_key[i] <= aes128_pkg::next_key(round_key[i-1], aes128_pkg::rcon(i-1));
    end
  end

endmodule

[rtl/aes128_round.sv]
// ----------------------------------------------------------------------------
// aes128_round
// one registered cipher round, encrypt or decrypt per word
// ----------------------------------------------------------------------------
module aes128_round #(
  parameter logic LAST = 1'b0
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  input  aes128_pkg::ctl_t    ctl_in,
  input  aes128_pkg::block_t  state_in,
  input  aes128_pkg::block_t  enc_key,
  input  aes128_pkg::block_t  dec_key,
  output aes128_pkg::ctl_t    ctl,
  output aes128_pkg::block_t  state
);

  aes128_pkg::block_t enc_val, dec_val, tmp_e, tmp_d;

  // forward: sub, shift, mix, add; inverse: shift, sub, add, mix; LAST skips mix
  always_comb begin
    tmp_e = aes128_pkg::shift_rows(aes128_pkg::sub_bytes(state_in, 1'b0), 1'b0);
    enc_val = (LAST ? tmp_e : aes128_pkg::mix_columns(tmp_e)) ^ enc_key;
    tmp_d = aes128_pkg::sub_bytes(aes128_pkg::shift_rows(state_in, 1'b1), 1'b1) ^ dec_key;
    dec_val = LAST ? tmp_d : aes128_pkg::inv_mix_columns(tmp_d);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else if (advance) begin
      ctl <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      state <= (ctl_in.opcode == aes128_pkg::OP_DECRYPT) ? dec_val : enc_val;
    end
  end

endmodule

[rtl/aes128_block_cipher_core.sv]
// ----------------------------------------------------------------------------
// aes128_block_cipher_core
// fully unrolled aes-128 encrypt/decrypt pipeline
// ----------------------------------------------------------------------------
// Usage: write key_high (addr 0x0) and key_low (addr 0x8) over the apb port
// while the core is idle. The round keys need time to settle, so in_ch
// holds ready low after reset and after every key write while they settle.
// Input words (opcode, block_high, block_low) arrive on in_ch; results leave
// on out_ch. Opcode 0 encrypts, 1 decrypts.
// Pipeline: one initial key-add stage plus ten round stages, passed in
// order. One word is accepted every cycle unless out_ch stalls or the round
// keys settle, since every stage hands its word on whenever output allows.
// Reset clears all valid bits and the key registers. When out_ch stalls the
// whole pipe holds; in_ch.ready drops only when the last stage is full and
// not being taken, or while the round keys settle, so no word is lost or
// repeated.
// ----------------------------------------------------------------------------
module aes128_block_cipher_core (
  input  logic               clk,
  input  logic               rst,
  aes128_in_if.sink          in_ch,
  aes128_out_if.source       out_ch,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready
);

  localparam logic [3:0] KEY_SETTLE = 4'd11;

  logic [63:0] key_high, key_low;
  aes128_pkg::block_t round_key [11];
  aes128_pkg::ctl_t   ctl [11];
  aes128_pkg::block_t state [11];
  logic advance;
  logic [3:0] key_wait;
  logic key_ready;

  // config registers
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low  <= '0;
    end else if (psel && penable && pwrite && paddr[2:0] == 3'd0) begin
      unique case (paddr[3])
        aes128_pkg::REG_KEY_HIGH: key_high <= pwdata;
        aes128_pkg::REG_KEY_LOW:  key_low  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2:0] == 3'd0) begin
      unique case (paddr[3])
        aes128_pkg::REG_KEY_HIGH: prdata = key_high;
        aes128_pkg::REG_KEY_LOW:  prdata = key_low;
        default: prdata = '0;
      endcase
    end
  end

  // hold off input until the round keys follow the key registers
  always_ff @(posedge clk) begin
    if (rst) begin
      key_wait <= KEY_SETTLE;
    end else if (psel && penable && pwrite) begin
      key_wait <= KEY_SETTLE;
    end else if (key_wait != 4'd0) begin
      key_wait <= key_wait - 4'd1;
    end
  end

  assign key_ready = (key_wait == 4'd0);

  aes128_keysched u_keys (
    .clk       (clk),
    .key       ({key_high, key_low}),
    .round_key (round_key)
  );

  // global stall when the output word is held
  assign advance = !ctl[10].valid || out_ch.ready;
  assign in_ch.ready = advance && key_ready;

  // initial key add
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl[0] <= '0;
    end else if (advance) begin
      ctl[0] <= '{valid: in_ch.valid && key_ready, opcode: in_ch.opcode};
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      state[0] <= {in_ch.block_high, in_ch.block_low} ^
                  ((in_ch.opcode == aes128_pkg::OP_DECRYPT) ? round_key[10] : round_key[0]);
    end
  end

  // ten round stages
  for (genvar g = 1; g < 11; g++) begin : g_round
    aes128_round #(.LAST(g == 10)) u_round (
      .clk      (clk),
      .rst      (rst),
      .advance  (advance),
      .ctl_in   (ctl[g-1]),
      .state_in (state[g-1]),
      .enc_key  (round_key[g]),
      .dec_key  (round_key[10-g]),
      .ctl      (ctl[g]),
      .state    (state[g])
    );
  end

  assign out_ch.valid       = ctl[10].valid;
  assign out_ch.result_high = state[10][127:64];
  assign out_ch.result_low  = state[10][63:0];

  // a held result stays valid with its high half unchanged
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.result_high))
    else $error("result changed under stall");
  // an accepted word reaches the output when out_ch never stalls meanwhile
  a_lat: assert property (@(posedge clk) disable iff (rst)
    in_ch.valid && in_ch.ready && out_ch.ready ##1 out_ch.ready ##1 out_ch.ready
    ##1 out_ch.ready ##1 out_ch.ready ##1 out_ch.ready ##1 out_ch.ready
    ##1 out_ch.ready ##1 out_ch.ready ##1 out_ch.ready ##1 out_ch.ready |=> out_ch.valid)
    else $error("word lost in pipe");
  // input is blocked only by a stalled output or settling round keys
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !in_ch.ready |-> (out_ch.valid && !out_ch.ready) || (key_wait != 4'd0))
    else $error("spurious backpressure");

endmodule

[verif/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the aes-128 block cipher core: an independent
// byte-level cipher model predicts every result word, a checker compares
// each word taken from the result channel, and keys are changed over apb
// between phases while both channels idle and stall at random
// ----------------------------------------------------------------------------
module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [3:0] ADDR_KEY_HIGH = {aes128_pkg::REG_KEY_HIGH, 3'b000};
  localparam logic [3:0] ADDR_KEY_LOW  = {aes128_pkg::REG_KEY_LOW, 3'b000};
  localparam int PIPE_LATENCY = 11;

  typedef struct {
    logic [63:0] result_high;
    logic [63:0] result_low;
  } cipher_word_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;

  aes128_in_if  in_ch ();
  aes128_out_if out_ch ();

  aes128_block_cipher_core DUT (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch.sink),
    .out_ch  (out_ch.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // model key and result bookkeeping
  logic [63:0]  model_key_high;
  logic [63:0]  model_key_low;
  cipher_word_t cipher_expected_q[$];
  logic [7:0]   fwd_sbox_tab[256];
  logic [7:0]   inv_sbox_tab[256];
  int           mismatch_count;
  int           words_checked;
  int           words_sent;
  int           send_idle_pct;
  int           recv_idle_pct;
  int           hold_request;
  int           hold_left;

  // clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // ---------------------------------------------------------------------------
  // cipher model
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] gf_mult(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    acc = 8'h00;
    for (int k = 0; k < 8; k++) begin
      if (b[k]) acc ^= a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    end
    return acc;
  endfunction

  // s-box from the field inverse and the affine map
  function automatic void build_sbox_tables();
    logic [7:0] b, s;
    for (int a = 0; a < 256; a++) begin
      b = 8'h00;
      for (int c = 1; c < 256; c++) begin
        if (gf_mult(a[7:0], c[7:0]) == 8'h01) b = c[7:0];
      end
      s = b ^ {b[6:0], b[7]} ^ {b[5:0], b[7:6]} ^ {b[4:0], b[7:5]} ^ {b[3:0], b[7:4]}
          ^ 8'h63;
      fwd_sbox_tab[a] = s;
      inv_sbox_tab[s] = a[7:0];
    end
  endfunction

  function automatic logic [127:0] aes_transform(input logic op, input logic [127:0] blk,
                                                 input logic [127:0] key);
    logic [7:0]   rk[176];
    logic [7:0]   st[16];
    logic [7:0]   tmp[16];
    logic [7:0]   w[4];
    logic [7:0]   col[4];
    logic [7:0]   coef[4];
    logic [7:0]   rc;
    logic [7:0]   f;
    logic [127:0] res;
    int           rnd;
    rc = 8'h01;
    for (int n = 0; n < 16; n++) begin
      rk[n] = key[127-8*n -: 8];
      st[n] = blk[127-8*n -: 8];
    end
    // round key expansion
    for (int i = 16; i < 176; i += 4) begin
      for (int j = 0; j < 4; j++) w[j] = rk[i-4+j];
      if (i % 16 == 0) begin
        f = w[0];
        w[0] = fwd_sbox_tab[w[1]] ^ rc;
        w[1] = fwd_sbox_tab[w[2]];
        w[2] = fwd_sbox_tab[w[3]];
        w[3] = fwd_sbox_tab[f];
        rc = gf_mult(rc, 8'h02);
      end
      for (int j = 0; j < 4; j++) rk[i+j] = rk[i-16+j] ^ w[j];
    end
    if (op == aes128_pkg::OP_DECRYPT) begin
      coef = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
    end else begin
      coef = '{8'h02, 8'h03, 8'h01, 8'h01};
    end
    rnd = (op == aes128_pkg::OP_DECRYPT) ? 10 : 0;
    for (int n = 0; n < 16; n++) st[n] ^= rk[16*rnd+n];
    for (int step = 1; step <= 10; step++) begin
      rnd = (op == aes128_pkg::OP_DECRYPT) ? 10 - step : step;
      // byte substitution and row shift
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 4; c++) begin
          if (op == aes128_pkg::OP_DECRYPT) begin
            tmp[r+4*((c+r)%4)] = inv_sbox_tab[st[r+4*c]];
          end else begin
            tmp[r+4*c] = fwd_sbox_tab[st[r+4*((c+r)%4)]];
          end
        end
      end
      st = tmp;
      if (op == aes128_pkg::OP_DECRYPT) begin
        for (int n = 0; n < 16; n++) st[n] ^= rk[16*rnd+n];
      end
      // column mix, skipped in the last round
      if (step < 10) begin
        for (int c = 0; c < 4; c++) begin
          for (int r = 0; r < 4; r++) col[r] = st[4*c+r];
          for (int r = 0; r < 4; r++) begin
            st[4*c+r] = 8'h00;
            for (int k = 0; k < 4; k++) st[4*c+r] ^= gf_mult(col[k], coef[(k-r+4)%4]);
          end
        end
      end
      if (op == aes128_pkg::OP_ENCRYPT) begin
        for (int n = 0; n < 16; n++) st[n] ^= rk[16*rnd+n];
      end
    end
    for (int n = 0; n < 16; n++) res[127-8*n -: 8] = st[n];
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  // send one word, record its expected result once accepted
  task automatic send_word(input logic op, input logic [63:0] hi, input logic [63:0] lo);
    cipher_word_t exp_word;
    logic [127:0] res;
    if ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_ch.valid      <= 1'b1;
    in_ch.opcode     <= op;
    in_ch.block_high <= hi;
    in_ch.block_low  <= lo;
    do @(posedge clk); while (!in_ch.ready);
    res = aes_transform(op, {hi, lo}, {model_key_high, model_key_low});
    exp_word.result_high = res[127:64];
    exp_word.result_low  = res[63:0];
    cipher_expected_q = {cipher_expected_q, exp_word};
    words_sent++;
  endtask

  task automatic stop_sending();
    in_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // wait for every expected word, then let the pipe drain
  task automatic wait_drained();
    stop_sending();
    while (cipher_expected_q.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 2) @(posedge clk);
  endtask

  // apb write: setup then access, then let round keys settle
  task automatic apb_write(input logic [3:0] addr, input logic [63:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (addr == ADDR_KEY_HIGH) model_key_high = data;
    else if (addr == ADDR_KEY_LOW) model_key_low = data;
    repeat (PIPE_LATENCY) @(posedge clk);
  endtask

  task automatic load_key(input logic [63:0] hi, input logic [63:0] lo);
    apb_write(ADDR_KEY_HIGH, hi);
    apb_write(ADDR_KEY_LOW, lo);
  endtask

  function automatic logic [63:0] rand_half();
    case ($urandom_range(9))
      0: return 64'h0;
      1: return '1;
      2: return 64'h1 << $urandom_range(63);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  // reset key (all zero), extreme blocks, both operations
  task automatic test_zero_key();
    send_word(aes128_pkg::OP_ENCRYPT, 64'h0, 64'h0);
    send_word(aes128_pkg::OP_DECRYPT, 64'h0, 64'h0);
    send_word(aes128_pkg::OP_ENCRYPT, '1, '1);
    send_word(aes128_pkg::OP_DECRYPT, '1, '1);
    send_word(aes128_pkg::OP_ENCRYPT, 64'h8000_0000_0000_0000, 64'h1);
    send_word(aes128_pkg::OP_DECRYPT, 64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555);
    wait_drained();
  endtask

  // standard known-answer key and block, round trip both ways
  task automatic test_known_answer();
    load_key(64'h0001_0203_0405_0607, 64'h0809_0a0b_0c0d_0e0f);
    send_word(aes128_pkg::OP_ENCRYPT, 64'h0011_2233_4455_6677, 64'h8899_aabb_ccdd_eeff);
    send_word(aes128_pkg::OP_DECRYPT, 64'h69c4_e0d8_6a7b_0430, 64'hd8cd_b780_70b4_c55a);
    send_word(aes128_pkg::OP_ENCRYPT, 64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa);
    send_word(aes128_pkg::OP_DECRYPT, 64'h1, 64'h8000_0000_0000_0000);
    wait_drained();
  endtask

  // all-ones key with extreme blocks
  task automatic test_ones_key();
    load_key('1, '1);
    send_word(aes128_pkg::OP_ENCRYPT, 64'h0, 64'h0);
    send_word(aes128_pkg::OP_DECRYPT, 64'h0, 64'h0);
    send_word(aes128_pkg::OP_ENCRYPT, '1, '1);
    send_word(aes128_pkg::OP_DECRYPT, '1, '1);
    send_word(aes128_pkg::OP_ENCRYPT, 64'h0, '1);
    send_word(aes128_pkg::OP_DECRYPT, '1, 64'h0);
    wait_drained();
  endtask

  // receiver holds off long while words keep coming, input must stall
  task automatic test_backpressure();
    load_key({$urandom, $urandom}, {$urandom, $urandom});
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_request  = 80;
    @(posedge clk);
    for (int i = 0; i < 40; i++) send_word($urandom_range(1), rand_half(), rand_half());
    wait_drained();
  endtask

  // sender pauses until every result is back, then resumes
  task automatic test_sender_pause();
    send_idle_pct = 10;
    recv_idle_pct = 10;
    for (int i = 0; i < 15; i++) send_word($urandom_range(1), rand_half(), rand_half());
    stop_sending();
    while (cipher_expected_q.size() != 0) @(posedge clk);
    for (int i = 0; i < 15; i++) send_word($urandom_range(1), rand_half(), rand_half());
    wait_drained();
  endtask

  // random words under one idling mode, key changed before each run
  task automatic test_random(input int send_pct, input int recv_pct, input int count);
    for (int k = 0; k < 3; k++) begin
      case (k)
        0: load_key(64'h0, {$urandom, $urandom});
        1: load_key({$urandom, $urandom}, '1);
        default: load_key({$urandom, $urandom}, {$urandom, $urandom});
      endcase
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      for (int i = 0; i < count / 3; i++) begin
        send_word($urandom_range(1), rand_half(), rand_half());
      end
      wait_drained();
    end
  endtask

  // ---------------------------------------------------------------------------
  // result checker and receiver stalls
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    cipher_word_t exp_word;
    if (rst) begin
      out_ch.ready <= 1'b0;
      hold_left = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        words_checked++;
        if (cipher_expected_q.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected word %h_%h", $time, out_ch.result_high,
                   out_ch.result_low);
        end else begin
          exp_word = cipher_expected_q.pop_front();
          if (out_ch.result_high !== exp_word.result_high) begin
            mismatch_count++;
            $display("%0t: result_high expected %h actual %h", $time,
                     exp_word.result_high, out_ch.result_high);
          end
          if (out_ch.result_low !== exp_word.result_low) begin
            mismatch_count++;
            $display("%0t: result_low expected %h actual %h", $time,
                     exp_word.result_low, out_ch.result_low);
          end
        end
      end
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst              = 1'b1;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    in_ch.valid      = 1'b0;
    in_ch.opcode     = aes128_pkg::OP_ENCRYPT;
    in_ch.block_high = '0;
    in_ch.block_low  = '0;
    model_key_high   = '0;
    model_key_low    = '0;
    mismatch_count   = 0;
    words_checked    = 0;
    words_sent       = 0;
    send_idle_pct    = 0;
    recv_idle_pct    = 0;
    hold_request     = 0;
    build_sbox_tables();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_zero_key();
    test_known_answer();
    test_ones_key();
    test_random(37, 47, 372);
    test_random(47, 37, 372);
    test_random(0, 0, 372);
    test_backpressure();
    test_sender_pause();

    $display("covered %0d words (encrypt and decrypt) over zero, all-ones and random keys,",
             words_sent);
    $display("%0d results checked under idling, long back-pressure and sender pauses",
             words_checked);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // run limit
  initial begin
    #3ms;
    $display("Mismatches found");
    $finish;
  end

endmodule

[files.f]
rtl/aes128_pkg.sv
rtl/aes128_if.sv
rtl/aes128_keysched.sv
rtl/aes128_round.sv
rtl/aes128_block_cipher_core.sv
verif/tb_top.sv
